[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker module of the gradient block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, aclk, arst_n, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!arst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, aclk, arst_n, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!arst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/fdg_pkg.sv]
// ----------------------------------------------------------------------------
// fdg_pkg
// Types and constants shared by the modules of the gradient block.
// ----------------------------------------------------------------------------
package fdg_pkg;

    localparam int unsigned DEF_MAX_ROWS    = 1024;
    localparam int unsigned DEF_SAMPLE_BITS = 32;

    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned ROW_COUNT_BITS = 11;
    localparam int unsigned COL_BITS       = 16;
    localparam int unsigned ROW_INDEX_BITS = 10;
    localparam int unsigned INV_BITS       = 32;
    localparam int unsigned FRAC_BITS      = 16;

    localparam logic [INV_BITS-1:0] INV_RESET = 32'h0001_0000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ROW_COUNT = 2'd0,
        REG_COL_COUNT = 2'd1,
        REG_INV_X     = 2'd2,
        REG_INV_Y     = 2'd3
    } cfg_reg_t;

    // Results that one sample can cause, in the order they are delivered.
    typedef enum logic [1:0] {
        JOB_LEFT   = 2'd0,
        JOB_UP     = 2'd1,
        JOB_CORNER = 2'd2
    } job_t;

    typedef struct packed {
        logic [ROW_INDEX_BITS-1:0] row_index;
        logic [COL_BITS-1:0]       col_index;
        logic                      run_last;
        logic                      frame_last;
    } fdg_tag_t;

endpackage

[rtl/core/fdg_ram.sv]
// ----------------------------------------------------------------------------
// fdg_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fdg_ram
#(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/fdg_scale.sv]
// ----------------------------------------------------------------------------
// fdg_scale
// Scales both differences by their spacing factors, rounds toward minus
// infinity, saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module fdg_scale
    import fdg_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS:0]   diff_x,
    input  logic                          half_x,
    input  logic signed [SAMPLE_BITS:0]   diff_y,
    input  logic                          half_y,
    input  fdg_tag_t                      tag_in,
    input  logic [INV_BITS-1:0]           inv_x,
    input  logic [INV_BITS-1:0]           inv_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] grad_x,
    output logic signed [SAMPLE_BITS-1:0] grad_y,
    output fdg_tag_t                      tag_out
);

    localparam int unsigned SB = SAMPLE_BITS;
    localparam int unsigned DW = SB + 1;
    localparam int unsigned PW = DW + INV_BITS;

    function automatic logic [DW-1:0] magnitude(input logic [DW-1:0] d);
        return d[DW-1] ? (~d + DW'(1)) : d;
    endfunction

    function automatic logic [SB-1:0] finish(input logic [PW-1:0] prod, input logic neg,
                                             input logic half);
        logic [PW:0]   bias;
        logic [PW:0]   sum;
        logic [PW:0]   q;
        logic [PW:0]   lim;
        logic [SB-1:0] res;
        bias = '0;
        if (neg)
        begin
            bias = {{(PW - FRAC_BITS){1'b0}}, half, {FRAC_BITS{1'b1}}};
        end
        sum = {1'b0, prod} + bias;
        q   = half ? (sum >> (FRAC_BITS + 1)) : (sum >> FRAC_BITS);
        lim = ((PW + 1)'(1) << (SB - 1)) - (neg ? (PW + 1)'(0) : (PW + 1)'(1));
        if (q > lim)
        begin
            q = lim;
        end
        res = q[SB-1:0];
        return neg ? (~res + SB'(1)) : res;
    endfunction

    logic          m_valid_reg;
    logic [DW-1:0] mag_x_reg;
    logic [DW-1:0] mag_y_reg;
    logic          m_neg_x_reg;
    logic          m_neg_y_reg;
    logic          m_half_x_reg;
    logic          m_half_y_reg;
    fdg_tag_t      m_tag_reg;

    logic          p_valid_reg;
    logic [PW-1:0] prod_x_reg;
    logic [PW-1:0] prod_y_reg;
    logic          p_neg_x_reg;
    logic          p_neg_y_reg;
    logic          p_half_x_reg;
    logic          p_half_y_reg;
    fdg_tag_t      p_tag_reg;

    logic          o_valid_reg;
    logic [SB-1:0] grad_x_reg;
    logic [SB-1:0] grad_y_reg;
    fdg_tag_t      o_tag_reg;

    logic o_ready;
    logic p_ready;

    assign o_ready  = !o_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign in_ready = !m_valid_reg || p_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                m_valid_reg <= in_valid;
            end
            if (p_ready)
            begin
                p_valid_reg <= m_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mag_x_reg    <= magnitude(diff_x);
            mag_y_reg    <= magnitude(diff_y);
            m_neg_x_reg  <= diff_x[DW-1];
            m_neg_y_reg  <= diff_y[DW-1];
            m_half_x_reg <= half_x;
            m_half_y_reg <= half_y;
            m_tag_reg    <= tag_in;
        end
        if (p_ready && m_valid_reg)
        begin
            prod_x_reg   <= PW'(mag_x_reg) * PW'(inv_x);
            prod_y_reg   <= PW'(mag_y_reg) * PW'(inv_y);
            p_neg_x_reg  <= m_neg_x_reg;
            p_neg_y_reg  <= m_neg_y_reg;
            p_half_x_reg <= m_half_x_reg;
            p_half_y_reg <= m_half_y_reg;
            p_tag_reg    <= m_tag_reg;
        end
        if (o_ready && p_valid_reg)
        begin
            grad_x_reg <= finish(prod_x_reg, p_neg_x_reg, p_half_x_reg);
            grad_y_reg <= finish(prod_y_reg, p_neg_y_reg, p_half_y_reg);
            o_tag_reg  <= p_tag_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign grad_x    = grad_x_reg;
    assign grad_y    = grad_y_reg;
    assign tag_out   = o_tag_reg;

endmodule

[rtl/core/finite_difference_gradient_2d.sv]
// ----------------------------------------------------------------------------
// finite_difference_gradient_2d
// Streaming two-dimensional gradient of a column-major Q16.16 matrix.
// ----------------------------------------------------------------------------
// The block takes one sample per cycle in column-major order, unless its
// result path stalls, and reports the gradient of element (r,c) when sample
// (r,c+1) is transferred; an element of the last column follows with the
// sample of the next row, the last element with its own sample. A sample
// in the last column causes up to three results, which leave one per cycle
// through the shared scaling pipeline unless it stalls, so the next sample
// waits until the last of them has been issued. The two previous columns
// are held in two RAMs of MAX_ROWS entries that are read when a sample is
// transferred and written back in the next cycle, with forwarding for
// back-to-back accesses to one row. No clearing pass is needed after reset.
// Any register write restarts the matrix at row 0, column 0.
// ----------------------------------------------------------------------------
module finite_difference_gradient_2d
    import fdg_pkg::*;
#(
    parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] grad_x,
    output logic signed [SAMPLE_BITS-1:0] grad_y,
    output logic [ROW_INDEX_BITS-1:0]     row_index,
    output logic [COL_BITS-1:0]           col_index,
    output logic                          run_last,
    output logic                          frame_last
);

    localparam int unsigned SB        = SAMPLE_BITS;
    localparam int unsigned DW        = SB + 1;
    localparam int unsigned ADDR_BITS = $clog2(MAX_ROWS);
    localparam int unsigned RCNT_BITS = $clog2(MAX_ROWS + 1);
    localparam int unsigned RCMP_BITS = (RCNT_BITS > ROW_COUNT_BITS) ? RCNT_BITS
                                                                      : ROW_COUNT_BITS;

    function automatic logic signed [DW-1:0] sub(input logic [SB-1:0] a,
                                                 input logic [SB-1:0] b);
        logic signed [DW-1:0] ae;
        logic signed [DW-1:0] be;
        ae = $signed({a[SB-1], a});
        be = $signed({b[SB-1], b});
        return ae - be;
    endfunction

    // Configuration and position state
    logic [RCNT_BITS-1:0] rows_reg;
    logic [COL_BITS-1:0]  cols_reg;
    logic [INV_BITS-1:0]  inv_x_reg;
    logic [INV_BITS-1:0]  inv_y_reg;
    logic [ADDR_BITS-1:0] row_pos_reg;
    logic [COL_BITS-1:0]  col_pos_reg;
    logic [SB-1:0]        prior_reg;
    logic [SB-1:0]        prior2_reg;

    logic [RCMP_BITS-1:0] rc_wide;
    logic [RCNT_BITS-1:0] rows_cfg;
    logic [COL_BITS-1:0]  cols_cfg;

    logic                 accept;
    logic                 at_last_row;
    logic                 at_last_col;
    logic [2:0]           jobs_new;
    logic [ADDR_BITS-1:0] row_pos_next;
    logic [COL_BITS-1:0]  col_pos_next;
    logic                 rows_gt1;
    logic                 cols_gt1;

    // Column stores
    logic [ADDR_BITS-1:0] b_raddr;
    logic [2*SB-1:0]      ram_a_rdata;
    logic [SB-1:0]        ram_b_rdata;
    logic [2*SB-1:0]      wdata_a;
    logic                 fwd_a_reg;
    logic                 fwd_b_reg;
    logic [2*SB-1:0]      fwd_a_data_reg;
    logic [SB-1:0]        fwd_b_data_reg;
    logic [2*SB-1:0]      a_res;
    logic [SB-1:0]        a_older;
    logic [SB-1:0]        a_newer;
    logic [SB-1:0]        b_newer;
    logic [SB-1:0]        last_newer_reg;

    // Result stage
    logic                 s1_valid_reg;
    logic [2:0]           s1_jobs_reg;
    logic [SB-1:0]        s1_sample_reg;
    logic [SB-1:0]        s1_p1_reg;
    logic [SB-1:0]        s1_p2_reg;
    logic [SB-1:0]        s1_up_reg;
    logic [ADDR_BITS-1:0] s1_row_reg;
    logic [COL_BITS-1:0]  s1_col_reg;
    logic                 s1_r0_reg;
    logic                 s1_r1_reg;
    logic                 s1_c1_reg;
    logic                 s1_last_row_reg;

    job_t                 job_sel;
    logic [2:0]           jobs_rest;
    logic                 emit;
    logic                 s1_done;
    logic signed [DW-1:0] dc;
    logic signed [DW-1:0] dr;
    logic                 shc;
    logic                 shr;
    fdg_tag_t             job_tag;

    logic                 s2_valid_reg;
    logic signed [DW-1:0] s2_diff_x_reg;
    logic signed [DW-1:0] s2_diff_y_reg;
    logic                 s2_half_x_reg;
    logic                 s2_half_y_reg;
    fdg_tag_t             s2_tag_reg;
    logic                 s2_ready;
    logic                 scale_in_ready;
    fdg_tag_t             out_tag;

    always_comb
    begin
        rc_wide = RCMP_BITS'(cfg_data[ROW_COUNT_BITS-1:0]);
        if (rc_wide == '0)
        begin
            rows_cfg = RCNT_BITS'(1);
        end
        else if (rc_wide > RCMP_BITS'(MAX_ROWS))
        begin
            rows_cfg = RCNT_BITS'(MAX_ROWS);
        end
        else
        begin
            rows_cfg = RCNT_BITS'(rc_wide);
        end
        cols_cfg = (cfg_data[COL_BITS-1:0] == '0) ? COL_BITS'(1) : cfg_data[COL_BITS-1:0];
    end

    assign accept      = in_valid && in_ready;
    assign rows_gt1    = rows_reg != RCNT_BITS'(1);
    assign cols_gt1    = cols_reg != COL_BITS'(1);
    assign at_last_row = (RCNT_BITS'(row_pos_reg) + RCNT_BITS'(1)) == rows_reg;
    assign at_last_col = col_pos_reg == (cols_reg - COL_BITS'(1));
    assign jobs_new    = {at_last_col && at_last_row,
                          at_last_col && (row_pos_reg != '0),
                          col_pos_reg != '0};

    always_comb
    begin
        row_pos_next = row_pos_reg + ADDR_BITS'(1);
        col_pos_next = col_pos_reg;
        if (at_last_row)
        begin
            row_pos_next = '0;
            col_pos_next = at_last_col ? '0 : (col_pos_reg + COL_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= RCNT_BITS'(1);
            cols_reg    <= COL_BITS'(1);
            inv_x_reg   <= INV_RESET;
            inv_y_reg   <= INV_RESET;
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            prior_reg   <= '0;
            prior2_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW_COUNT: rows_reg  <= rows_cfg;
                REG_COL_COUNT: cols_reg  <= cols_cfg;
                REG_INV_X:     inv_x_reg <= cfg_data[INV_BITS-1:0];
                REG_INV_Y:     inv_y_reg <= cfg_data[INV_BITS-1:0];
                default:       ;
            endcase
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (accept)
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            prior_reg   <= sample;
            prior2_reg  <= prior_reg;
        end
    end

    // Each entry of store A holds {column c-2, column c-1}; store B is a copy of
    // column c-1 that serves the look-ahead read of the next row.
    assign b_raddr = row_pos_reg + ADDR_BITS'(1);
    assign wdata_a = {a_newer, s1_sample_reg};

    fdg_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_ROWS)
    ) u_ram_a (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_row_reg),
        .wdata (wdata_a),
        .re    (accept),
        .raddr (row_pos_reg),
        .rdata (ram_a_rdata)
    );

    fdg_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_ROWS)
    ) u_ram_b (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_row_reg),
        .wdata (s1_sample_reg),
        .re    (accept),
        .raddr (b_raddr),
        .rdata (ram_b_rdata)
    );

    assign a_res   = fwd_a_reg ? fwd_a_data_reg : ram_a_rdata;
    assign a_older = a_res[2*SB-1:SB];
    assign a_newer = a_res[SB-1:0];
    assign b_newer = fwd_b_reg ? fwd_b_data_reg : ram_b_rdata;

    always_comb
    begin
        job_sel = JOB_CORNER;
        if (s1_jobs_reg[JOB_LEFT])
        begin
            job_sel = JOB_LEFT;
        end
        else if (s1_jobs_reg[JOB_UP])
        begin
            job_sel = JOB_UP;
        end
        jobs_rest          = s1_jobs_reg;
        jobs_rest[job_sel] = 1'b0;
    end

    assign emit     = s1_valid_reg && (s1_jobs_reg != '0) && s2_ready;
    assign s1_done  = s1_valid_reg && ((s1_jobs_reg == '0) || (emit && (jobs_rest == '0)));
    assign in_ready = !s1_valid_reg || s1_done;

    always_comb
    begin
        dc                = '0;
        dr                = '0;
        shc               = 1'b0;
        shr               = 1'b0;
        job_tag.row_index = ROW_INDEX_BITS'(s1_row_reg);
        job_tag.col_index = s1_col_reg;
        job_tag.run_last  = jobs_rest == '0;
        job_tag.frame_last = 1'b0;
        case (job_sel)
            JOB_LEFT:
            begin
                job_tag.col_index = s1_col_reg - COL_BITS'(1);
                if (s1_c1_reg)
                begin
                    dc = sub(s1_sample_reg, a_newer);
                end
                else
                begin
                    dc  = sub(s1_sample_reg, a_older);
                    shc = 1'b1;
                end
                if (!rows_gt1)
                begin
                    dr = '0;
                end
                else if (s1_r0_reg)
                begin
                    dr = sub(b_newer, a_newer);
                end
                else if (s1_last_row_reg)
                begin
                    dr = sub(a_newer, s1_up_reg);
                end
                else
                begin
                    dr  = sub(b_newer, s1_up_reg);
                    shr = 1'b1;
                end
            end
            JOB_UP:
            begin
                job_tag.row_index = ROW_INDEX_BITS'(s1_row_reg - ADDR_BITS'(1));
                if (cols_gt1)
                begin
                    dc = sub(s1_p1_reg, s1_up_reg);
                end
                if (s1_r1_reg)
                begin
                    dr = sub(s1_sample_reg, s1_p1_reg);
                end
                else
                begin
                    dr  = sub(s1_sample_reg, s1_p2_reg);
                    shr = 1'b1;
                end
            end
            JOB_CORNER:
            begin
                job_tag.frame_last = 1'b1;
                if (cols_gt1)
                begin
                    dc = sub(s1_sample_reg, a_newer);
                end
                if (rows_gt1)
                begin
                    dr = sub(s1_sample_reg, s1_p1_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_jobs_reg  <= '0;
            fwd_a_reg    <= 1'b0;
            fwd_b_reg    <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_jobs_reg  <= jobs_new;
                fwd_a_reg    <= s1_valid_reg && (row_pos_reg == s1_row_reg);
                fwd_b_reg    <= s1_valid_reg && (b_raddr == s1_row_reg);
            end
            else
            begin
                if (s1_done)
                begin
                    s1_valid_reg <= 1'b0;
                end
                if (emit)
                begin
                    s1_jobs_reg <= jobs_rest;
                end
            end
            if (s2_ready)
            begin
                s2_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            last_newer_reg <= a_newer;
        end
        if (accept)
        begin
            fwd_a_data_reg  <= wdata_a;
            fwd_b_data_reg  <= s1_sample_reg;
            s1_sample_reg   <= sample;
            s1_p1_reg       <= prior_reg;
            s1_p2_reg       <= prior2_reg;
            s1_up_reg       <= s1_valid_reg ? a_newer : last_newer_reg;
            s1_row_reg      <= row_pos_reg;
            s1_col_reg      <= col_pos_reg;
            s1_r0_reg       <= row_pos_reg == '0;
            s1_r1_reg       <= row_pos_reg == ADDR_BITS'(1);
            s1_c1_reg       <= col_pos_reg == COL_BITS'(1);
            s1_last_row_reg <= at_last_row;
        end
        if (emit)
        begin
            s2_diff_x_reg <= cols_gt1 ? dc : dr;
            s2_half_x_reg <= cols_gt1 ? shc : shr;
            s2_diff_y_reg <= rows_gt1 ? dr : dc;
            s2_half_y_reg <= rows_gt1 ? shr : shc;
            s2_tag_reg    <= job_tag;
        end
    end

    assign s2_ready = !s2_valid_reg || scale_in_ready;

    fdg_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_ready  (scale_in_ready),
        .diff_x    (s2_diff_x_reg),
        .half_x    (s2_half_x_reg),
        .diff_y    (s2_diff_y_reg),
        .half_y    (s2_half_y_reg),
        .tag_in    (s2_tag_reg),
        .inv_x     (inv_x_reg),
        .inv_y     (inv_y_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .grad_x    (grad_x),
        .grad_y    (grad_y),
        .tag_out   (out_tag)
    );

    assign row_index  = out_tag.row_index;
    assign col_index  = out_tag.col_index;
    assign run_last   = out_tag.run_last;
    assign frame_last = out_tag.frame_last;

endmodule

[rtl/core/fdg_checker.sv]
// ----------------------------------------------------------------------------
// fdg_checker
// Port-level checks on the result stream of the gradient block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdg_checker
    import fdg_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] grad_x,
    input logic signed [SAMPLE_BITS-1:0] grad_y,
    input logic [ROW_INDEX_BITS-1:0]     row_index,
    input logic [COL_BITS-1:0]           col_index,
    input logic                          run_last,
    input logic                          frame_last
);

    // The final result of a matrix is always the last one of its sample.
    `ASSERT_NOW(a_frame_ends_run, clk, rst_n, out_valid && frame_last, run_last)

    // The results of one sample leave without a gap between transfers.
    `ASSERT_NEXT(a_run_unbroken, clk, rst_n, out_valid && out_ready && !run_last, out_valid)

    `ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(grad_x) && $stable(grad_y) && $stable(row_index) && $stable(col_index) && $stable(run_last) && $stable(frame_last))

endmodule

bind finite_difference_gradient_2d fdg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fdg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .grad_x     (grad_x),
    .grad_y     (grad_y),
    .row_index  (row_index),
    .col_index  (col_index),
    .run_last   (run_last),
    .frame_last (frame_last)
);

[sim/tb_finite_difference_gradient_2d.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_finite_difference_gradient_2d
// Self-checking testbench for the streaming two-dimensional gradient block.
// ----------------------------------------------------------------------------
// Matrices of several shapes and spacing factors are streamed through the
// block. A predictor computes every gradient result at the moment its
// sample transfer is made, and a monitor compares each result transfer
// with the oldest prediction. Both sides idle at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_finite_difference_gradient_2d;
    import fdg_pkg::*;

    localparam int  MAXR      = 1024;
    localparam int  SETTLE    = 20;
    localparam int  LIMIT     = 400000;
    localparam longint SMAX   = 64'sd2147483647;
    localparam longint SMIN   = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic [9:0]         row;
        logic [15:0]        col;
        logic               rl;
        logic               fl;
    } grad_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [31:0]   sample;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [31:0]   grad_x;
    logic signed [31:0]   grad_y;
    logic [9:0]           row_index;
    logic [15:0]          col_index;
    logic                 run_last;
    logic                 frame_last;

    logic signed [31:0]   sample_q[$];
    grad_res_t            grad_q[$];
    int                   cyc;
    int                   errors;
    int                   hold_cnt;
    bit                   hold_done;
    bit                   hold_go;
    bit                   burst;

    logic [10:0]          m_rows_cfg;
    logic [15:0]          m_cols_cfg;
    logic [31:0]          m_inv_x;
    logic [31:0]          m_inv_y;
    logic signed [31:0]   older_col[MAXR];
    logic signed [31:0]   newer_col[MAXR];
    int                   row_pos;
    int                   col_pos;
    logic signed [31:0]   prev1;
    logic signed [31:0]   prev2;

    finite_difference_gradient_2d u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .sample(sample), .out_valid(out_valid), .out_ready(out_ready),
        .grad_x(grad_x), .grad_y(grad_y), .row_index(row_index),
        .col_index(col_index), .run_last(run_last), .frame_last(frame_last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic signed [31:0] scale_diff(longint d, logic [31:0] inv, int sh);
        logic signed [97:0] p;
        logic signed [97:0] q;
        p = d * $signed({1'b0, inv});
        q = p >>> sh;
        if (q > SMAX)
            return 32'sh7FFF_FFFF;
        if (q < SMIN)
            return 32'sh8000_0000;
        return q[31:0];
    endfunction

    function automatic longint col_store(bit newer, int i, int rows);
        if (i < 0 || i >= rows || i >= MAXR)
            return 0;
        return newer ? longint'(newer_col[i]) : longint'(older_col[i]);
    endfunction

    function automatic longint axis_delta(int pos, int n, longint prv, longint ctr,
                                          longint nxt, output int sh);
        sh = 16;
        if (n <= 1)
            return 0;
        if (pos == 0)
            return nxt - ctr;
        if (pos == n - 1)
            return ctr - prv;
        sh = 17;
        return nxt - prv;
    endfunction

    task automatic push_grad(int er, int ec, longint ctr, longint lf, longint rt,
                             longint up, longint dn, int rows, int cols, bit fl);
        grad_res_t g;
        int  shc;
        int  shr;
        longint dc;
        longint dr;
        dc = axis_delta(ec, cols, lf, ctr, rt, shc);
        dr = axis_delta(er, rows, up, ctr, dn, shr);
        g.gx  = scale_diff(cols > 1 ? dc : dr, m_inv_x, cols > 1 ? shc : shr);
        g.gy  = scale_diff(rows > 1 ? dr : dc, m_inv_y, rows > 1 ? shr : shc);
        g.row = er[9:0];
        g.col = ec[15:0];
        g.rl  = 1'b0;
        g.fl  = fl;
        grad_q.push_back(g);
    endtask

    task automatic take_sample(logic signed [31:0] s);
        int rows;
        int cols;
        int r;
        int c;
        int n;
        rows = (m_rows_cfg == 0) ? 1 : (m_rows_cfg > MAXR ? MAXR : m_rows_cfg);
        cols = (m_cols_cfg == 0) ? 1 : m_cols_cfg;
        r = row_pos;
        c = col_pos;
        n = 0;
        if (r >= rows || c >= cols)
        begin
            r = 0;
            c = 0;
        end
        if (c >= 1)
        begin
            push_grad(r, c - 1, col_store(1, r, rows), col_store(0, r, rows), s,
                      col_store(0, r - 1, rows), col_store(1, r + 1, rows),
                      rows, cols, 1'b0);
            n++;
        end
        if (c == cols - 1)
        begin
            if (r >= 1)
            begin
                push_grad(r - 1, c, prev1, col_store(0, r - 1, rows), 0, prev2, s,
                          rows, cols, 1'b0);
                n++;
            end
            if (r == rows - 1)
            begin
                push_grad(r, c, s, col_store(1, r, rows), 0, prev1, 0,
                          rows, cols, 1'b1);
                n++;
            end
        end
        if (n > 0)
            grad_q[grad_q.size() - 1].rl = 1'b1;
        older_col[r] = newer_col[r];
        newer_col[r] = s;
        prev2 = prev1;
        prev1 = s;
        r++;
        if (r >= rows)
        begin
            r = 0;
            c++;
            if (c >= cols)
                c = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            REG_ROW_COUNT: m_rows_cfg = v[10:0];
            REG_COL_COUNT: m_cols_cfg = v[15:0];
            REG_INV_X:     m_inv_x    = v;
            REG_INV_Y:     m_inv_y    = v;
            default:       ;
        endcase
        row_pos = 0;
        col_pos = 0;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sample_q.size() != 0 || in_valid || grad_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_shape(int rows, int cols, logic [31:0] ix, logic [31:0] iy);
        wait_idle();
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COL_COUNT, cols);
        write_reg(REG_INV_X, ix);
        write_reg(REG_INV_Y, iy);
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $signed($urandom_range(0, 4095)) - 2048;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_inv();
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0001;
            1:       return 32'hFFFF_FFFF;
            2:       return INV_RESET;
            default: return $urandom;
        endcase
    endfunction

    task automatic feed(int count);
        for (int i = 0; i < count; i++)
            sample_q.push_back(rand_sample());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                take_sample(sample);
            if (!in_valid || in_ready)
            begin
                if (sample_q.size() != 0 &&
                    (burst || $urandom_range(0, 99) >= 18))
                begin
                    in_valid <= 1'b1;
                    sample   <= sample_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (grad_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer at row %0d col %0d",
                                 row_index, col_index);
                end
                else
                begin
                    grad_res_t g;
                    g = grad_q.pop_front();
                    if (g.gx !== grad_x || g.gy !== grad_y || g.row !== row_index ||
                        g.col !== col_index || g.rl !== run_last || g.fl !== frame_last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %0d %0d r%0d c%0d %b%b got %0d %0d r%0d c%0d %b%b",
                                     g.gx, g.gy, g.row, g.col, g.rl, g.fl, grad_x, grad_y,
                                     row_index, col_index, run_last, frame_last);
                    end
                end
            end
            hold_go = !hold_done && cyc >= 300 && sample_q.size() > 8;
            if (hold_go)
            begin
                hold_cnt  <= 400;
                hold_done <= 1'b1;
            end
            else if (hold_cnt > 0)
                hold_cnt <= hold_cnt - 1;
            out_ready <= (hold_cnt <= 1 && !hold_go) &&
                         (burst || $urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT)
        begin
            $display("tb_finite_difference_gradient_2d NOT OK");
            $finish;
        end
    end

    initial
    begin
        int total;
        int rows;
        int cols;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ROW_COUNT;
        cfg_data  = '0;
        m_rows_cfg = 1;
        m_cols_cfg = 1;
        m_inv_x   = INV_RESET;
        m_inv_y   = INV_RESET;
        row_pos   = 0;
        col_pos   = 0;
        prev1     = '0;
        prev2     = '0;
        burst     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        sample_q.push_back(32'sh7FFF_FFFF);
        sample_q.push_back(32'sh8000_0000);
        set_shape(2, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        sample_q.push_back(32'sh7FFF_FFFF);
        sample_q.push_back(32'sh8000_0000);
        sample_q.push_back(32'sh8000_0000);
        sample_q.push_back(32'sh7FFF_FFFF);
        set_shape(1, 4, 32'h0, INV_RESET);
        feed(4);
        set_shape(3, 1, 32'h1, 32'hFFFF_FFFF);
        feed(3);
        set_shape(0, 0, INV_RESET, 32'h0);
        feed(2);
        set_shape(3, 3, 32'h0003_0000, 32'h0000_8000);
        feed(9);

        set_shape(2047, 1, $urandom, $urandom);
        feed(64);
        set_shape(1, 65535, rand_inv(), rand_inv());
        feed(30);

        total = 0;
        while (total < 320)
        begin
            rows = $urandom_range(1, 7);
            cols = $urandom_range(1, 7);
            burst = (total >= 100 && total < 250);
            set_shape(rows, cols, rand_inv(), rand_inv());
            feed(rows * cols);
            total += rows * cols;
        end

        wait_idle();
        if (errors == 0)
            $display("tb_finite_difference_gradient_2d OK");
        else
            $display("tb_finite_difference_gradient_2d NOT OK");
        $finish;
    end
endmodule
